>>> design/asp_pkg.sv
// Package for the aliquot sum / perfect-number test.
// Widths, derived constants and the control structs shared between the modules.
// No dependencies.
package asp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int SUM_WIDTH   = 35;

  // trial divisor never exceeds ceil(sqrt(2^VALUE_WIDTH))
  localparam int TRIAL_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int SQ_WIDTH    = 2 * TRIAL_WIDTH;
  localparam int ACC_WIDTH   = ((SUM_WIDTH > VALUE_WIDTH) ? SUM_WIDTH : VALUE_WIDTH) + 1;
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_status_t;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

endpackage

>>> design/asp_query_if.sv
// Input channel of the aliquot sum block: one value per item.
// Depends on asp_pkg.
interface asp_query_if;
  logic                           valid;
  logic                           ready;
  logic [asp_pkg::VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> design/asp_result_if.sv
// Output channel of the aliquot sum block: divisor sum and perfect flag.
// Depends on asp_pkg.
interface asp_result_if;
  logic                         valid;
  logic                         ready;
  logic [asp_pkg::SUM_WIDTH-1:0] divisor_sum;
  logic                         is_perfect;

  modport source (output valid, output divisor_sum, output is_perfect, input ready);
  modport sink   (input valid, input divisor_sum, input is_perfect, output ready);
endinterface

>>> design/asp_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on asp_pkg.
module asp_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [asp_pkg::VALUE_WIDTH-1:0]  dividend,
  input  logic [asp_pkg::TRIAL_WIDTH-1:0]  divisor,
  output logic [asp_pkg::VALUE_WIDTH-1:0]  quotient,
  output asp_pkg::div_status_t             status
);

  localparam int W  = asp_pkg::VALUE_WIDTH;
  localparam int DW = asp_pkg::TRIAL_WIDTH;
  localparam int CW = asp_pkg::CNT_WIDTH;

  logic [W-1:0]  work;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, work[W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        work <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (diff[DW]) begin
          rem <= trial[DW-1:0];
        end else begin
          rem <= diff[DW-1:0];
        end
        work <= {work[W-2:0], ~diff[DW]};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient        = work;
  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
`endif

endmodule

>>> design/asp_acc.sv
// Saturating accumulator for the divisor sum.
// Depends on asp_pkg.
module asp_acc (
  input  logic                            clk,
  input  asp_pkg::acc_ctrl_t              ctrl,
  input  logic [asp_pkg::VALUE_WIDTH-1:0] term,
  output logic [asp_pkg::SUM_WIDTH-1:0]   sum,
  output logic                            over
);

  localparam int AW = asp_pkg::ACC_WIDTH;
  localparam logic [asp_pkg::SUM_WIDTH-1:0] SumMax = '1;

  logic [AW-1:0] total;

  assign total = AW'(sum) + AW'(term);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum  <= asp_pkg::SUM_WIDTH'(1);
      over <= 1'b0;
    end else if (ctrl.add) begin
      if (over || total > AW'(SumMax)) begin
        sum  <= SumMax;
        over <= 1'b1;
      end else begin
        sum <= total[asp_pkg::SUM_WIDTH-1:0];
      end
    end
  end

endmodule

>>> design/aliquot_sum_perfect_test.sv
// Aliquot sum and perfect-number test by trial division, bit-serial divider.
// Items are handled one at a time; each trial divisor d with d*d <= value goes
// through the serial divider (one bit per cycle), plus one or two adds per exact
// divisor (d, and the quotient if it differs); values < 4 need no division, and
// the next item is taken while a result still waits on the output register.
// Reset: synchronous, active high; clears control state and the output valid.
module aliquot_sum_perfect_test (
  input  logic               clk,
  input  logic               rst,
  asp_query_if.sink          query,
  asp_result_if.source       result
);

  localparam int W  = asp_pkg::VALUE_WIDTH;
  localparam int DW = asp_pkg::TRIAL_WIDTH;
  localparam int SW = asp_pkg::SQ_WIDTH;
  localparam int AW = asp_pkg::ACC_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_ADD_D,
    S_ADD_Q,
    S_STEP,
    S_DONE
  } state_t;

  state_t                     state;
  logic [W-1:0]               v;
  logic [DW-1:0]              d;
  logic [SW-1:0]              sq;
  logic                       out_valid;
  logic [asp_pkg::SUM_WIDTH-1:0] out_sum;
  logic                       out_perfect;

  logic                       sq_le;
  logic                       div_start;
  logic [W-1:0]               quot;
  asp_pkg::div_status_t       div_st;
  asp_pkg::acc_ctrl_t         acc_ctl;
  logic [W-1:0]               term;
  logic [asp_pkg::SUM_WIDTH-1:0] sum;
  logic                       over;
  logic                       accept;

  assign accept    = query.valid && query.ready;
  assign sq_le     = sq <= SW'(v);
  assign div_start = (state == S_TEST) && sq_le;
  assign term      = (state == S_ADD_Q) ? quot : W'(d);

  assign acc_ctl.clear = accept;
  assign acc_ctl.add   = (state == S_ADD_D) || (state == S_ADD_Q);

  asp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (v),
    .divisor  (d),
    .quotient (quot),
    .status   (div_st)
  );

  asp_acc u_acc (
    .clk  (clk),
    .ctrl (acc_ctl),
    .term (term),
    .sum  (sum),
    .over (over)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            v     <= query.value;
            d     <= DW'(2);
            sq    <= SW'(4);
            state <= S_TEST;
          end
        end
        S_TEST: begin
          state <= sq_le ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= div_st.rem_zero ? S_ADD_D : S_STEP;
          end
        end
        S_ADD_D: begin
          state <= (quot != W'(d)) ? S_ADD_Q : S_STEP;
        end
        S_ADD_Q: begin
          state <= S_STEP;
        end
        S_STEP: begin
          d     <= d + 1'b1;
          sq    <= sq + SW'({d, 1'b1});
          state <= S_TEST;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid   <= 1'b1;
            out_sum     <= sum;
            out_perfect <= (v > W'(1)) && !over && (AW'(v) == AW'(sum));
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign query.ready        = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.divisor_sum = out_sum;
  assign result.is_perfect  = out_perfect;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !query.ready)
    else $error("input taken again while an item is in progress");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");
  a_square_tracks: assert property (@(posedge clk) disable iff (rst)
    state == S_TEST |-> sq == SW'(d) * SW'(d))
    else $error("running square lost track of trial divisor");
  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the done state");
`endif

endmodule
